FILE: rtl/hsf_pkg.sv
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared constants and types of the scaled forward filter: register indexes,
// sequencer states and the control word that drives the per-state lanes.
// ----------------------------------------------------------------------------
package hsf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_STATES    = 2;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRANS_00 = 3'd0,
		CFG_TRANS_01 = 3'd1,
		CFG_TRANS_10 = 3'd2,
		CFG_TRANS_11 = 3'd3,
		CFG_INIT_0   = 3'd4,
		CFG_INIT_1   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_SUM,
		ST_DIV,
		ST_WB
	} state_t;

	typedef enum logic [2:0] {
		LOP_HOLD,
		LOP_MAC_FIRST,
		LOP_MAC_NEXT,
		LOP_PROPAGATE,
		LOP_LOAD,
		LOP_DIV
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		logic     first_step;
		logic     div_first;
	} lane_ctrl_t;

endpackage

FILE: rtl/hsf_in_if.sv
// ----------------------------------------------------------------------------
// hsf_in_if
// Input channel: one beat carries the two emission densities of a time step.
// ----------------------------------------------------------------------------
interface hsf_in_if #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] dens_s0;
	logic [FRAC_BITS-1:0] dens_s1;
	logic                 first_step;

	modport source (output valid, output dens_s0, output dens_s1, output first_step,
		input ready);
	modport sink (input valid, input dens_s0, input dens_s1, input first_step,
		output ready);
endinterface

FILE: rtl/hsf_out_if.sv
// ----------------------------------------------------------------------------
// hsf_out_if
// Result channel: normalized alphas, scale sum and zero-sum flag per beat.
// ----------------------------------------------------------------------------
interface hsf_out_if #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [FRAC_BITS:0] alpha_s0;
	logic [FRAC_BITS:0] alpha_s1;
	logic [FRAC_BITS:0] scale_sum;
	logic               zero_scale;

	modport source (output valid, output alpha_s0, output alpha_s1, output scale_sum,
		output zero_scale, input ready);
	modport sink (input valid, input alpha_s0, input alpha_s1, input scale_sum,
		input zero_scale, output ready);
endinterface

FILE: rtl/hsf_cfg_if.sv
// ----------------------------------------------------------------------------
// hsf_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface hsf_cfg_if #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [hsf_pkg::CFG_IDX_W-1:0] index;
	logic [FRAC_BITS:0]            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hmm_scaled_forward_filter_core.sv
// ----------------------------------------------------------------------------
// hmm_scaled_forward_filter_core
// Scaled forward recursion of a two-state hidden Markov model in fixed point.
// ----------------------------------------------------------------------------
// One step per input beat, one result beat per step. A continuing step runs
// through MUL_A, MUL_B, MUL_C, SUM, DIV and WB, a first step skips MUL_B and
// MUL_C: each state lane shares one multiplier over the two transition
// products and the density product, then a restoring divider in each lane
// produces one quotient bit per cycle in DIV. The next beat is taken in the
// cycle after the result is written to the output register, even while that
// result waits; a stalled output holds the step in WB. Configuration writes
// are always ready; values above one are clamped to one.
module hmm_scaled_forward_filter_core #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hsf_in_if.sink     in_ch,
	hsf_out_if.source  out_ch,
	hsf_cfg_if.sink    cfg_ch
);
	localparam int NS = hsf_pkg::NUM_STATES;
	localparam int PW = FRAC_BITS + 1;
	localparam int UW = 2 * FRAC_BITS + 1;
	localparam int AW = 2 * FRAC_BITS + 2;
	localparam int CW = $clog2(FRAC_BITS + 2);
	localparam int ONE_I   = 1 << FRAC_BITS;
	localparam int SELF_I  = (9 * ONE_I + 5) / 10;
	localparam int OTHER_I = (ONE_I + 5) / 10;
	localparam logic [PW-1:0] ONE   = PW'(ONE_I);
	localparam logic [PW-1:0] SELF  = PW'(SELF_I);
	localparam logic [PW-1:0] OTHER = PW'(OTHER_I);
	localparam logic [PW-1:0] HALF_P = PW'(ONE_I / 2);
	localparam logic [CW-1:0] DIV_LAST = CW'(FRAC_BITS + 1);

	hsf_pkg::state_t     state_q, state_d;
	hsf_pkg::lane_ctrl_t lane_ctrl;

	logic [PW-1:0]        trans_q [NS][NS];
	logic [PW-1:0]        init_q  [NS];
	logic [PW-1:0]        prev_q  [NS];
	logic [FRAC_BITS-1:0] dens_q  [NS];
	logic                 first_q;
	logic [CW-1:0]        div_cnt_q;
	logic [PW-1:0]        cfg_val;

	logic [UW-1:0] lane_u     [NS];
	logic [PW-1:0] lane_alpha [NS];
	logic [PW-1:0] mrg_alpha  [NS];
	logic [AW-1:0] mrg_sum;
	logic [PW-1:0] mrg_scale;
	logic          mrg_zero;

	logic          out_valid_q;
	logic [PW-1:0] out_alpha0_q;
	logic [PW-1:0] out_alpha1_q;
	logic [PW-1:0] out_scale_q;
	logic          out_zero_q;

	logic in_take;
	logic out_free;
	logic out_load;
	logic mrg_load;

	// configuration registers
	assign cfg_ch.ready = 1'b1;
	assign cfg_val      = (cfg_ch.data > ONE) ? ONE : cfg_ch.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q[0][0] <= SELF;
			trans_q[0][1] <= OTHER;
			trans_q[1][0] <= OTHER;
			trans_q[1][1] <= SELF;
			init_q[0]     <= HALF_P;
			init_q[1]     <= HALF_P;
		end else if (cfg_ch.valid) begin
			case (hsf_pkg::cfg_reg_t'(cfg_ch.index))
				hsf_pkg::CFG_TRANS_00: trans_q[0][0] <= cfg_val;
				hsf_pkg::CFG_TRANS_01: trans_q[0][1] <= cfg_val;
				hsf_pkg::CFG_TRANS_10: trans_q[1][0] <= cfg_val;
				hsf_pkg::CFG_TRANS_11: trans_q[1][1] <= cfg_val;
				hsf_pkg::CFG_INIT_0:   init_q[0]     <= cfg_val;
				hsf_pkg::CFG_INIT_1:   init_q[1]     <= cfg_val;
				default: ;
			endcase
		end
	end

	// sequencer
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hsf_pkg::ST_IDLE:  if (in_ch.valid) state_d = hsf_pkg::ST_MUL_A;
			hsf_pkg::ST_MUL_A: state_d = first_q ? hsf_pkg::ST_SUM : hsf_pkg::ST_MUL_B;
			hsf_pkg::ST_MUL_B: state_d = hsf_pkg::ST_MUL_C;
			hsf_pkg::ST_MUL_C: state_d = hsf_pkg::ST_SUM;
			hsf_pkg::ST_SUM:   state_d = hsf_pkg::ST_DIV;
			hsf_pkg::ST_DIV:   if (div_cnt_q == DIV_LAST) state_d = hsf_pkg::ST_WB;
			hsf_pkg::ST_WB:    if (out_free) state_d = hsf_pkg::ST_IDLE;
			default:           state_d = hsf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		lane_ctrl.op         = hsf_pkg::LOP_HOLD;
		lane_ctrl.first_step = first_q;
		lane_ctrl.div_first  = (div_cnt_q == '0);
		in_take  = 1'b0;
		mrg_load = 1'b0;
		out_load = 1'b0;
		case (state_q)
			hsf_pkg::ST_IDLE:  in_take = 1'b1;
			hsf_pkg::ST_MUL_A: lane_ctrl.op = hsf_pkg::LOP_MAC_FIRST;
			hsf_pkg::ST_MUL_B: lane_ctrl.op = hsf_pkg::LOP_MAC_NEXT;
			hsf_pkg::ST_MUL_C: lane_ctrl.op = hsf_pkg::LOP_PROPAGATE;
			hsf_pkg::ST_SUM: begin
				lane_ctrl.op = hsf_pkg::LOP_LOAD;
				mrg_load     = 1'b1;
			end
			hsf_pkg::ST_DIV:   lane_ctrl.op = hsf_pkg::LOP_DIV;
			hsf_pkg::ST_WB:    out_load = out_free;
			default: ;
		endcase
	end

	assign in_ch.ready = in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hsf_pkg::ST_IDLE;
			first_q   <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_take && in_ch.valid) begin
				first_q <= in_ch.first_step;
			end
			if (mrg_load) begin
				div_cnt_q <= '0;
			end else if (state_q == hsf_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_ch.valid) begin
			dens_q[0] <= in_ch.dens_s0;
			dens_q[1] <= in_ch.dens_s1;
		end
	end

	// stored alphas of the previous step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (out_load) begin
			for (int i = 0; i < NS; i++) begin
				prev_q[i] <= mrg_alpha[i];
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_lane
		hsf_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk          (clk),
			.ctrl         (lane_ctrl),
			.prev_alpha_0 (prev_q[0]),
			.prev_alpha_1 (prev_q[1]),
			.trans_from0  (trans_q[0][i]),
			.trans_from1  (trans_q[1][i]),
			.init_prob    (init_q[i]),
			.dens         (dens_q[i]),
			.den          (mrg_sum),
			.u            (lane_u[i]),
			.alpha        (lane_alpha[i])
		);
	end

	hsf_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk        (clk),
		.load       (mrg_load),
		.lane_u     (lane_u),
		.lane_alpha (lane_alpha),
		.sum        (mrg_sum),
		.scale_sum  (mrg_scale),
		.zero_scale (mrg_zero),
		.alpha      (mrg_alpha)
	);

	// output register, holds a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_alpha0_q <= mrg_alpha[0];
			out_alpha1_q <= mrg_alpha[1];
			out_scale_q  <= mrg_scale;
			out_zero_q   <= mrg_zero;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.alpha_s0   = out_alpha0_q;
	assign out_ch.alpha_s1   = out_alpha1_q;
	assign out_ch.scale_sum  = out_scale_q;
	assign out_ch.zero_scale = out_zero_q;
endmodule

FILE: rtl/hsf_lane.sv
// ----------------------------------------------------------------------------
// hsf_lane
// One hidden-state lane: a shared multiplier does the transition MAC and the
// density product, then a restoring divider forms u * ONE / S one bit a cycle.
// ----------------------------------------------------------------------------
module hsf_lane #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  hsf_pkg::lane_ctrl_t      ctrl,
	input  logic [FRAC_BITS:0]       prev_alpha_0,
	input  logic [FRAC_BITS:0]       prev_alpha_1,
	input  logic [FRAC_BITS:0]       trans_from0,
	input  logic [FRAC_BITS:0]       trans_from1,
	input  logic [FRAC_BITS:0]       init_prob,
	input  logic [FRAC_BITS-1:0]     dens,
	input  logic [2*FRAC_BITS+1:0]   den,
	output logic [2*FRAC_BITS:0]     u,
	output logic [FRAC_BITS:0]       alpha
);
	localparam int PW = FRAC_BITS + 1;
	localparam int SW = FRAC_BITS + 2;
	localparam int MW = 2 * FRAC_BITS + 3;
	localparam int AW = 2 * FRAC_BITS + 2;
	localparam int UW = 2 * FRAC_BITS + 1;
	localparam int RW = 2 * FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 2;
	localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

	logic [SW-1:0] mul_x;
	logic [PW-1:0] mul_y;
	logic [MW-1:0] mul_p;
	logic [AW-1:0] acc_q;
	logic [UW-1:0] u_q;
	logic [RW-1:0] r_q;
	logic [QW-1:0] q_q;
	logic [RW:0]   rem_sh;
	logic [RW:0]   den_x;
	logic [RW:0]   rem_diff;
	logic          rem_ge;
	logic [QW:0]   q_inc;

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (ctrl.op)
			hsf_pkg::LOP_MAC_FIRST: begin
				if (ctrl.first_step) begin
					mul_x = SW'(init_prob);
					mul_y = PW'(dens);
				end else begin
					mul_x = SW'(prev_alpha_0);
					mul_y = trans_from0;
				end
			end
			hsf_pkg::LOP_MAC_NEXT: begin
				mul_x = SW'(prev_alpha_1);
				mul_y = trans_from1;
			end
			hsf_pkg::LOP_PROPAGATE: begin
				// rounded propagated alpha times density
				mul_x = acc_q[FRAC_BITS +: SW];
				mul_y = PW'(dens);
			end
			default: ;
		endcase
	end

	assign mul_p = MW'(mul_x) * MW'(mul_y);

	// first division step compares without shifting
	assign rem_sh   = ctrl.div_first ? {1'b0, r_q} : {r_q, 1'b0};
	assign den_x    = (RW+1)'(den);
	assign rem_ge   = rem_sh >= den_x;
	assign rem_diff = rem_sh - den_x;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			hsf_pkg::LOP_MAC_FIRST: begin
				if (ctrl.first_step) begin
					u_q <= mul_p[UW-1:0];
				end else begin
					acc_q <= mul_p[AW-1:0] + HALF;
				end
			end
			hsf_pkg::LOP_MAC_NEXT: begin
				acc_q <= acc_q + mul_p[AW-1:0];
			end
			hsf_pkg::LOP_PROPAGATE: begin
				u_q <= mul_p[UW-1:0];
			end
			hsf_pkg::LOP_LOAD: begin
				r_q <= RW'(u_q);
				q_q <= '0;
			end
			hsf_pkg::LOP_DIV: begin
				r_q <= rem_ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
				q_q <= {q_q[QW-2:0], rem_ge};
			end
			default: ;
		endcase
	end

	assign q_inc = (QW+1)'(q_q) + (QW+1)'(1);
	assign alpha = q_inc[PW:1];
	assign u     = u_q;
endmodule

FILE: rtl/hsf_merge.sv
// ----------------------------------------------------------------------------
// hsf_merge
// Combines the lanes: scale sum, rounded and saturated scale output, zero-sum
// flag, and zero forcing of the normalized alphas.
// ----------------------------------------------------------------------------
module hsf_merge #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   load,
	input  logic [2*FRAC_BITS:0]   lane_u     [hsf_pkg::NUM_STATES],
	input  logic [FRAC_BITS:0]     lane_alpha [hsf_pkg::NUM_STATES],
	output logic [2*FRAC_BITS+1:0] sum,
	output logic [FRAC_BITS:0]     scale_sum,
	output logic                   zero_scale,
	output logic [FRAC_BITS:0]     alpha      [hsf_pkg::NUM_STATES]
);
	localparam int PW = FRAC_BITS + 1;
	localparam int AW = 2 * FRAC_BITS + 2;
	localparam logic [AW:0] HALF = (AW+1)'(1) << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS+2:0] SS_MAX = (FRAC_BITS+3)'({PW{1'b1}});

	logic [AW-1:0]        sum_w;
	logic [AW:0]          sum_rnd;
	logic [FRAC_BITS+2:0] ss_full;
	logic [AW-1:0]        sum_q;
	logic [PW-1:0]        ss_q;
	logic                 zero_q;

	always_comb begin
		sum_w = '0;
		for (int i = 0; i < hsf_pkg::NUM_STATES; i++) begin
			sum_w = sum_w + AW'(lane_u[i]);
		end
	end

	assign sum_rnd = (AW+1)'(sum_w) + HALF;
	assign ss_full = sum_rnd[AW:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (load) begin
			sum_q  <= sum_w;
			zero_q <= (sum_w == '0);
			ss_q   <= (ss_full > SS_MAX) ? {PW{1'b1}} : ss_full[PW-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < hsf_pkg::NUM_STATES; i++) begin
			alpha[i] = zero_q ? '0 : lane_alpha[i];
		end
	end

	assign sum        = sum_q;
	assign scale_sum  = ss_q;
	assign zero_scale = zero_q;
endmodule
